>>> rtl/assert_macros.svh
// Shared assertion macros for the accumulator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

>>> rtl/smha_pkg.sv
// ----------------------------------------------------------------------------
// smha_pkg
// Shared constants and types for the sample accumulator.
// ----------------------------------------------------------------------------
package smha_pkg;
  localparam int NUM_SAMPLES = 1024;
  localparam int COUNT_BITS  = 24;
  localparam int IDX_W  = 10;
  localparam int PSUM_W = COUNT_BITS + 18;
  localparam int HSUM_W = COUNT_BITS + 16;
  localparam int ENTRY_W = PSUM_W + HSUM_W + 2 * COUNT_BITS;
  localparam int FRAC_W = 17;
  localparam int DIV_W  = PSUM_W + 17;
  localparam int CFG_AW = 4;

  localparam logic [CFG_AW-1:0] REG_THRESHOLD = 4'd0;
  localparam logic [CFG_AW-1:0] REG_FILT_EN   = 4'd4;
  localparam logic [CFG_AW-1:0] REG_FILT_CHR  = 4'd8;

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [PSUM_W-1:0]     psum;
    logic [HSUM_W-1:0]     hsum;
    logic [COUNT_BITS-1:0] ccnt;
    logic [COUNT_BITS-1:0] hcnt;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  num;
    logic [DIV_W-1:0]  den;
  } div_req_t;
endpackage

>>> rtl/smha_ram.sv
// ----------------------------------------------------------------------------
// smha_ram
// Generic single-port-write, single-read RAM with registered read.
// ----------------------------------------------------------------------------
module smha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/smha_div.sv
// ----------------------------------------------------------------------------
// smha_div
// Restoring divider giving a Q1.16 quotient saturated at 1.0, one bit a cycle.
// ----------------------------------------------------------------------------
module smha_div (
  input  logic                    clk,
  input  logic                    rst,
  input  smha_pkg::div_req_t      req,
  output logic                    done,
  output logic [smha_pkg::FRAC_W-1:0] quot
);
  import smha_pkg::*;

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] den;
  logic [FRAC_W-1:0] q;
  logic [4:0] cnt;
  logic busy;
  logic [DIV_W:0] trial;

  assign trial = {rem, 1'b0} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (req.num >= req.den) begin
          quot <= FRAC_W'(1 << 16);
          done <= 1'b1;
        end else begin
          rem  <= req.num;
          den  <= req.den;
          q    <= '0;
          cnt  <= 5'd16;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (!trial[DIV_W]) begin
          rem <= trial[DIV_W-1:0];
          q   <= {q[FRAC_W-2:0], 1'b1};
        end else begin
          rem <= {rem[DIV_W-2:0], 1'b0};
          q   <= {q[FRAC_W-2:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
          quot <= {q[FRAC_W-2:0], !trial[DIV_W]};
        end
      end
    end
  end
endmodule

>>> rtl/sample_missingness_het_accumulator_unit.sv
// ----------------------------------------------------------------------------
// sample_missingness_het_accumulator_unit
// Per-sample missingness and heterozygosity totals with ratio queries.
// ----------------------------------------------------------------------------
// After reset a clearing pass writes all 1024 entries, one a cycle, with busy
// high. An accumulate goes through memory read, modify and write back. In a
// query the bit-serial divider forms the four ratios one after another, and
// a ratio with a fixed answer is set without the divider. done pulses for one
// cycle with a result; the receiver cannot stall it.
`include "assert_macros.svh"
module sample_missingness_het_accumulator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [9:0]  sample_index,
  input  logic [7:0]  chromosome,
  input  logic [15:0] prob_hom_first,
  input  logic [15:0] prob_het,
  input  logic [15:0] prob_hom_second,
  input  logic        last_sample,
  output logic        done,
  output logic [9:0]  queried_sample,
  output logic [16:0] missing_prob_frac,
  output logic [16:0] missing_call_frac,
  output logic [16:0] het_prob_frac,
  output logic [16:0] het_call_frac,
  output logic [3:0]  undefined_mask,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [smha_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import smha_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_WRITE, S_QSETUP, S_DIV, S_WAIT, S_OUT
  } state_t;

  state_t state;
  logic [15:0] call_threshold;
  logic filter_enable;
  logic [7:0] filter_chromosome;
  logic [COUNT_BITS-1:0] variant_count;

  logic [IDX_W-1:0] clr_idx;
  logic r_op, r_valid;
  logic [IDX_W-1:0] r_idx;
  logic [17:0] r_psum_add;
  logic [15:0] r_het;
  logic r_call, r_hcall;

  entry_t rd_entry, wr_entry, q_entry;
  logic we;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] raddr;
  logic [1:0] ratio;
  logic [3:0] mask;
  logic [FRAC_W-1:0] frac [4];
  div_req_t dreq;
  logic ddone;
  logic [FRAC_W-1:0] dquot;

  logic [PSUM_W-1:0] vq;
  logic [15:0] mx01, mx;
  logic [PSUM_W:0] psum_s;
  logic [HSUM_W:0] hsum_s;
  logic [COUNT_BITS:0] ccnt_s, hcnt_s;
  logic wr_cfg, filtered;

  assign pready = 1'b1;
  assign wr_cfg = psel && penable && pwrite;
  assign busy = (state != S_IDLE);
  assign filtered = filter_enable && (chromosome != filter_chromosome);
  assign mx01 = (prob_hom_first > prob_het) ? prob_hom_first : prob_het;
  assign mx = (prob_hom_second > mx01) ? prob_hom_second : mx01;
  assign vq = PSUM_W'({variant_count, 15'd0});
  assign raddr = (state == S_IDLE) ? sample_index : r_idx;

  always_comb begin
    unique case (paddr)
      REG_THRESHOLD: prdata = {16'd0, call_threshold};
      REG_FILT_EN:   prdata = {31'd0, filter_enable};
      REG_FILT_CHR:  prdata = {24'd0, filter_chromosome};
      default:       prdata = '0;
    endcase
  end

  smha_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_SAMPLES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wr_entry),
    .raddr(raddr), .rdata(rd_entry)
  );

  smha_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quot(dquot));

  always_comb begin
    psum_s = {1'b0, rd_entry.psum} + PSUM_W'(r_psum_add);
    hsum_s = {1'b0, rd_entry.hsum} + HSUM_W'(r_het);
    ccnt_s = {1'b0, rd_entry.ccnt} + COUNT_BITS'(r_call);
    hcnt_s = {1'b0, rd_entry.hcnt} + COUNT_BITS'(r_hcall);
    we = 1'b0;
    waddr = r_idx;
    wr_entry.psum = psum_s[PSUM_W] ? '1 : psum_s[PSUM_W-1:0];
    wr_entry.hsum = hsum_s[HSUM_W] ? '1 : hsum_s[HSUM_W-1:0];
    wr_entry.ccnt = ccnt_s[COUNT_BITS] ? '1 : ccnt_s[COUNT_BITS-1:0];
    wr_entry.hcnt = hcnt_s[COUNT_BITS] ? '1 : hcnt_s[COUNT_BITS-1:0];
    if (state == S_CLEAR) begin
      we = 1'b1;
      waddr = clr_idx;
      wr_entry = '0;
    end else if (state == S_WRITE && r_op == OP_ACCUM && r_valid) begin
      we = 1'b1;
    end
  end

  // Divider request for the current ratio; skip ratios whose answer is fixed.
  always_comb begin
    dreq = '0;
    if (state == S_DIV) begin
      unique case (ratio)
        2'd0: begin
          dreq.start = (variant_count != 0) && (q_entry.psum < vq);
          dreq.num = DIV_W'(vq - q_entry.psum);
          dreq.den = DIV_W'(vq);
        end
        2'd1: begin
          dreq.start = (variant_count != 0) && (q_entry.ccnt < variant_count);
          dreq.num = DIV_W'(variant_count - q_entry.ccnt);
          dreq.den = DIV_W'(variant_count);
        end
        2'd2: begin
          dreq.start = (q_entry.psum != 0);
          dreq.num = DIV_W'(q_entry.hsum);
          dreq.den = DIV_W'(q_entry.psum);
        end
        default: begin
          dreq.start = (q_entry.ccnt != 0);
          dreq.num = DIV_W'(q_entry.hcnt);
          dreq.den = DIV_W'(q_entry.ccnt);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      done <= 1'b0;
      variant_count <= '0;
      call_threshold <= 16'd29491;
      filter_enable <= 1'b0;
      filter_chromosome <= '0;
    end else begin
      done <= 1'b0;
      if (wr_cfg) begin
        unique case (paddr)
          REG_THRESHOLD: call_threshold <= pwdata[15:0];
          REG_FILT_EN:   filter_enable <= pwdata[0];
          REG_FILT_CHR:  filter_chromosome <= pwdata[7:0];
          default: ;
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == IDX_W'(NUM_SAMPLES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            r_op <= opcode;
            r_idx <= sample_index;
            r_valid <= (opcode == OP_QUERY) || !filtered;
            r_psum_add <= 18'(prob_hom_first) + 18'(prob_het) + 18'(prob_hom_second);
            r_het <= prob_het;
            r_call <= (mx >= call_threshold);
            r_hcall <= (prob_het >= call_threshold);
            if (opcode == OP_ACCUM && !filtered && last_sample &&
                variant_count != '1) begin
              variant_count <= variant_count + 1'b1;
            end
            state <= S_READ;
          end
        end
        S_READ: state <= (r_op == OP_QUERY) ? S_QSETUP : S_WRITE;
        S_WRITE: state <= S_IDLE;
        S_QSETUP: begin
          q_entry <= rd_entry;
          ratio <= 2'd0;
          mask <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (dreq.start) begin
            state <= S_WAIT;
          end else begin
            frac[ratio] <= '0;
            if (ratio == 2'd0 && variant_count == 0) mask[0] <= 1'b1;
            if (ratio == 2'd1 && variant_count == 0) mask[1] <= 1'b1;
            if (ratio == 2'd2 && q_entry.psum == 0) mask[2] <= 1'b1;
            if (ratio == 2'd3 && q_entry.ccnt == 0) mask[3] <= 1'b1;
            ratio <= ratio + 2'd1;
            if (ratio == 2'd3) state <= S_OUT;
          end
        end
        S_WAIT: begin
          if (ddone) begin
            frac[ratio] <= dquot;
            ratio <= ratio + 2'd1;
            state <= (ratio == 2'd3) ? S_OUT : S_DIV;
          end
        end
        S_OUT: begin
          done <= 1'b1;
          queried_sample <= r_idx;
          missing_prob_frac <= frac[0];
          missing_call_frac <= frac[1];
          het_prob_frac <= frac[2];
          het_call_frac <= frac[3];
          undefined_mask <= mask;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_done_from_out, clk, rst, state == S_OUT, done)
  `ASSERT_IMPLY(a_no_accept_clear, clk, rst, state == S_CLEAR, busy)
  `ASSERT_IMPLY(a_write_only_accum, clk, rst, we && state != S_CLEAR, r_op == OP_ACCUM)
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives accumulate and query commands into the sample accumulator across
// several filter and threshold settings and idle patterns, predicts each
// query's ratios from a local copy of the per-sample totals, and compares
// every result field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import smha_pkg::*;

  typedef struct packed {
    logic        op;
    logic [9:0]  idx;
    logic [7:0]  chrom;
    logic [15:0] p0;
    logic [15:0] p1;
    logic [15:0] p2;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic [9:0]  idx;
    logic [16:0] mp;
    logic [16:0] mc;
    logic [16:0] fhp;
    logic [16:0] fhc;
    logic [3:0]  mask;
  } ratios_t;

  localparam logic [63:0] CNT_MAX  = (64'd1 << COUNT_BITS) - 1;
  localparam logic [63:0] PSUM_MAX = (64'd1 << PSUM_W) - 1;
  localparam logic [63:0] HSUM_MAX = (64'd1 << HSUM_W) - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic opcode = 1'b0;
  logic [9:0] sample_index = '0;
  logic [7:0] chromosome = '0;
  logic [15:0] prob_hom_first = '0, prob_het = '0, prob_hom_second = '0;
  logic last_sample = 1'b0;
  logic done;
  logic [9:0] queried_sample;
  logic [16:0] missing_prob_frac, missing_call_frac, het_prob_frac, het_call_frac;
  logic [3:0] undefined_mask;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  sample_missingness_het_accumulator_unit DUT (.*);

  always #2 clk = ~clk;

  cmd_t    pending_cmds[$];
  ratios_t expected_ratios[$];
  int      send_idle_pct = 0;
  int      errors = 0;
  logic    in_flight = 1'b0;

  logic [15:0] thr;
  logic        filt_en;
  logic [7:0]  filt_chr;
  logic [63:0] variants;
  logic [63:0] psum[NUM_SAMPLES];
  logic [63:0] ccnt[NUM_SAMPLES];
  logic [63:0] hsum[NUM_SAMPLES];
  logic [63:0] hcnt[NUM_SAMPLES];

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
    logic [63:0] s;
    s = a + b;
    return (s > lim) ? lim : s;
  endfunction

  function automatic logic [16:0] q16_ratio(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    if (num >= den) return 17'd65536;
    q = (num << 16) / den;
    return (q > 64'd65536) ? 17'd65536 : q[16:0];
  endfunction

  function automatic void apply_cmd(cmd_t c);
    logic [63:0] ps, cc, hp, hc, vq, mx;
    ratios_t r;
    if (c.op == OP_ACCUM) begin
      if (filt_en && c.chrom != filt_chr) return;
      mx = (c.p0 > c.p1) ? 64'(c.p0) : 64'(c.p1);
      if (64'(c.p2) > mx) mx = 64'(c.p2);
      psum[c.idx] = sat_add(psum[c.idx], 64'(c.p0) + c.p1 + c.p2, PSUM_MAX);
      hsum[c.idx] = sat_add(hsum[c.idx], 64'(c.p1), HSUM_MAX);
      if (mx >= 64'(thr)) ccnt[c.idx] = sat_add(ccnt[c.idx], 64'd1, CNT_MAX);
      if (c.p1 >= thr) hcnt[c.idx] = sat_add(hcnt[c.idx], 64'd1, CNT_MAX);
      if (c.last) variants = sat_add(variants, 64'd1, CNT_MAX);
      return;
    end
    ps = psum[c.idx]; cc = ccnt[c.idx]; hp = hsum[c.idx]; hc = hcnt[c.idx];
    r = '0;
    r.idx = c.idx;
    if (variants == 0) begin
      r.mask[1:0] = 2'b11;
    end else begin
      vq = variants * 64'd32768;
      r.mp = (ps >= vq) ? 17'd0 : q16_ratio(vq - ps, vq);
      r.mc = (cc >= variants) ? 17'd0 : q16_ratio(variants - cc, variants);
    end
    if (ps == 0) r.mask[2] = 1'b1;
    else r.fhp = q16_ratio(hp, ps);
    if (cc == 0) r.mask[3] = 1'b1;
    else r.fhc = q16_ratio(hc, cc);
    expected_ratios.push_back(r);
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (start && !busy) begin
      apply_cmd(pending_cmds.pop_front());
    end
    if (!rst && (!start || !busy)) begin
      if (pending_cmds.size() > 0 && !(start && !busy && pending_cmds.size() == 0)
          && $urandom_range(99) >= send_idle_pct) begin
        opcode          <= pending_cmds[0].op;
        sample_index    <= pending_cmds[0].idx;
        chromosome      <= pending_cmds[0].chrom;
        prob_hom_first  <= pending_cmds[0].p0;
        prob_het        <= pending_cmds[0].p1;
        prob_hom_second <= pending_cmds[0].p2;
        last_sample     <= pending_cmds[0].last;
        start           <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    ratios_t w;
    if (!rst && done) begin
      if (expected_ratios.size() == 0) begin
        report("unexpected transfer sample", 64'(queried_sample), 64'd0);
      end else begin
        w = expected_ratios.pop_front();
        if (queried_sample != w.idx)
          report("queried_sample", 64'(queried_sample), 64'(w.idx));
        if (missing_prob_frac != w.mp)
          report("missing_prob_frac", 64'(missing_prob_frac), 64'(w.mp));
        if (missing_call_frac != w.mc)
          report("missing_call_frac", 64'(missing_call_frac), 64'(w.mc));
        if (het_prob_frac != w.fhp)
          report("het_prob_frac", 64'(het_prob_frac), 64'(w.fhp));
        if (het_call_frac != w.fhc)
          report("het_call_frac", 64'(het_call_frac), 64'(w.fhc));
        if (undefined_mask != w.mask)
          report("undefined_mask", 64'(undefined_mask), 64'(w.mask));
      end
    end
  end

  task automatic drain();
    while (pending_cmds.size() > 0 || start || busy || expected_ratios.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (addr)
      REG_THRESHOLD: thr = val[15:0];
      REG_FILT_EN:   filt_en = val[0];
      default:       filt_chr = val[7:0];
    endcase
  endtask

  function automatic logic [15:0] rand_prob();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'($urandom_range(65535));
      default: return 16'($urandom_range(32768));
    endcase
  endfunction

  function automatic cmd_t rand_cmd(int hot);
    cmd_t c;
    c.op    = ($urandom_range(99) < 12) ? OP_QUERY : OP_ACCUM;
    c.idx   = ($urandom_range(9) < 8) ? 10'($urandom_range(hot)) : 10'($urandom_range(1023));
    c.chrom = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
    c.p0    = rand_prob();
    c.p1    = rand_prob();
    c.p2    = rand_prob();
    c.last  = ($urandom_range(3) == 0);
    return c;
  endfunction

  function automatic cmd_t mk(logic op, logic [9:0] i, logic [7:0] ch, logic [15:0] a,
                              logic [15:0] b, logic [15:0] d, logic l);
    cmd_t c;
    c.op = op; c.idx = i; c.chrom = ch; c.p0 = a; c.p1 = b; c.p2 = d; c.last = l;
    return c;
  endfunction

  initial begin
    int pcts[4] = '{0, 77, 0, 14};
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      psum[i] = 0; ccnt[i] = 0; hsum[i] = 0; hcnt[i] = 0;
    end
    variants = 0; thr = 16'd29491; filt_en = 1'b0; filt_chr = 8'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    pending_cmds.push_back(mk(OP_QUERY, 10'd0, 8'd0, 16'd0, 16'd0, 16'd0, 1'b0));
    pending_cmds.push_back(mk(OP_QUERY, 10'd1023, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    pending_cmds.push_back(mk(OP_ACCUM, 10'd0, 8'd0, 16'd32768, 16'd0, 16'd0, 1'b1));
    pending_cmds.push_back(mk(OP_ACCUM, 10'd1, 8'd0, 16'd0, 16'd32768, 16'd0, 1'b1));
    pending_cmds.push_back(mk(OP_ACCUM, 10'd2, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    pending_cmds.push_back(mk(OP_ACCUM, 10'd3, 8'd255, 16'd29491, 16'd29490, 16'd0, 1'b0));
    pending_cmds.push_back(mk(OP_ACCUM, 10'd1023, 8'd7, 16'd0, 16'd0, 16'd32768, 1'b1));
    pending_cmds.push_back(mk(OP_ACCUM, 10'd4, 8'd0, 16'd0, 16'd0, 16'd0, 1'b0));
    for (int i = 0; i < 5; i++)
      pending_cmds.push_back(mk(OP_QUERY, 10'(i), 8'd0, 16'd0, 16'd0, 16'd0, 1'b0));
    pending_cmds.push_back(mk(OP_QUERY, 10'd1023, 8'd0, 16'd0, 16'd0, 16'd0, 1'b0));
    drain();

    write_reg(REG_FILT_EN, 32'd1);
    write_reg(REG_FILT_CHR, 32'd255);
    write_reg(REG_THRESHOLD, 32'd0);
    pending_cmds.push_back(mk(OP_ACCUM, 10'd5, 8'd255, 16'd0, 16'd0, 16'd0, 1'b1));
    pending_cmds.push_back(mk(OP_ACCUM, 10'd5, 8'd254, 16'd100, 16'd100, 16'd0, 1'b1));
    pending_cmds.push_back(mk(OP_QUERY, 10'd5, 8'd0, 16'd0, 16'd0, 16'd0, 1'b0));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(REG_THRESHOLD, 32'd32768); write_reg(REG_FILT_EN, 32'd0); end
        1: begin write_reg(REG_THRESHOLD, 32'd16384); write_reg(REG_FILT_CHR, 32'd0); end
        2: begin write_reg(REG_FILT_EN, 32'd1); write_reg(REG_FILT_CHR, 32'd2); end
        3: begin write_reg(REG_THRESHOLD, 32'd29491); write_reg(REG_FILT_EN, 32'd0); end
        4: write_reg(REG_THRESHOLD, 32'd0);
        5: write_reg(REG_THRESHOLD, 32'($urandom_range(32768)));
        6: begin write_reg(REG_FILT_EN, 32'd1); write_reg(REG_FILT_CHR, 32'd0); end
        default: begin write_reg(REG_FILT_EN, 32'd0); write_reg(REG_THRESHOLD, 32'd20000); end
      endcase
      send_idle_pct = pcts[ph % 4];
      for (int k = 0; k < 150; k++) pending_cmds.push_back(rand_cmd(ph < 4 ? 7 : 63));
      drain();
    end

    if (errors == 0) begin
      $display("sample_missingness_het_accumulator_unit: match");
    end else begin
      $display("sample_missingness_het_accumulator_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("sample_missingness_het_accumulator_unit: mismatch");
    $finish;
  end
endmodule
